/* sv/wfa_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the worst-fit allocator.
// No dependencies; used by every module of the block except wfa_div.
package wfa_pkg;

    localparam int DEF_MAX_BLOCKS = 64;
    localparam int DEF_UNIT_WIDTH = 16;
    localparam int CFG_W          = 16;
    localparam int DATA_W         = 32;
    localparam int REQ_W          = 2;
    localparam int STATUS_W       = 3;

    localparam logic [CFG_W-1:0] UNIT_BYTES_RST  = 16'd16;
    localparam logic [CFG_W-1:0] TOTAL_UNITS_RST = 16'd4096;

    // Configuration register indexes
    localparam logic CFG_UNIT_BYTES  = 1'b0;
    localparam logic CFG_TOTAL_UNITS = 1'b1;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_CLEAR = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SIZE_ZERO = 3'd1,
        ST_NO_FIT    = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_ADDR  = 3'd4,
        ST_NOT_ALLOC = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_DIV, S_SCAN, S_INS, S_FSCAN, S_DEL, S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_ACCEPT, OP_CLEAR, OP_DIV, OP_SCAN_INIT,
        OP_SCAN, OP_INS, OP_FSCAN, OP_DEL, OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        MODE_SCAN, MODE_INS, MODE_DEL
    } t_mode;

    typedef struct packed {
        t_op     op;
        logic    set_st;
        t_status st;
    } t_cmd;

    typedef struct packed {
        t_req req;
        logic size_zero;
        logic full;
        logic div_busy;
        logic bad_addr;
        logic scan_last;
        logic found;
        logic match;
        logic at_target;
        logic del_last;
        logic out_busy;
    } t_sts;

endpackage

/* sv/wfa_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
// Uses no package items.
module wfa_div #(
    parameter int DW = 32,
    parameter int VW = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quot,
    output logic [VW-1:0] o_rem
);
    localparam int CNW = $clog2(DW + 1);

    logic [CNW-1:0] r_cnt, n_cnt;
    logic [DW-1:0]  r_q, n_q;
    logic [VW-1:0]  r_rem, n_rem;
    logic [VW:0]    trial;
    logic [VW:0]    diff;

    always_comb begin
        trial = {r_rem, r_q[DW-1]};
        diff  = trial - {1'b0, i_divisor};
        n_cnt = r_cnt;
        n_q   = r_q;
        n_rem = r_rem;
        if (i_start) begin
            n_cnt = CNW'(DW);
            n_q   = i_dividend;
            n_rem = '0;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - CNW'(1);
            if (trial >= {1'b0, i_divisor}) begin
                n_rem = diff[VW-1:0];
                n_q   = {r_q[DW-2:0], 1'b1};
            end else begin
                n_rem = trial[VW-1:0];
                n_q   = {r_q[DW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
    end

    assign o_busy = (r_cnt != '0);
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule

/* sv/wfa_dp.sv */
`timescale 1ns / 1ps
// Datapath: config registers, block table memory, divider, scan and result register.
// Depends on wfa_pkg and wfa_div.
module wfa_dp #(
    parameter int MAX_BLOCKS = wfa_pkg::DEF_MAX_BLOCKS,
    parameter int UNIT_WIDTH = wfa_pkg::DEF_UNIT_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [wfa_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [2*wfa_pkg::DATA_W-1:0]  i_in_data,
    input  logic [wfa_pkg::REQ_W-1:0]     i_in_user,
    input  wfa_pkg::t_cmd                 i_cmd,
    output wfa_pkg::t_sts                 o_sts,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [wfa_pkg::DATA_W-1:0]    o_out_data,
    output logic [wfa_pkg::STATUS_W-1:0]  o_out_user
);
    localparam int UW   = UNIT_WIDTH;
    localparam int DW   = wfa_pkg::DATA_W;
    localparam int CFW  = wfa_pkg::CFG_W;
    localparam int AW   = $clog2(MAX_BLOCKS);
    localparam int CW   = $clog2(MAX_BLOCKS + 1);
    localparam int HW   = (UW > CFW) ? UW : CFW;
    localparam int GW   = HW + 2;
    localparam int NW   = DW + 1;
    localparam int CMPW = (GW > NW) ? GW : NW;
    localparam int PW   = UW + CFW;
    localparam int EW   = 2 * UW;

    // configuration
    logic [CFW-1:0] r_unit_bytes, r_total_units;
    logic [CFW-1:0] unit;

    // request
    wfa_pkg::t_req  r_req;
    logic [DW-1:0]  r_size, r_addr;

    // table
    logic [EW-1:0]  r_mem [MAX_BLOCKS];
    logic [EW-1:0]  r_rd;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_idx, n_idx;
    wfa_pkg::t_mode r_mode, n_mode;
    logic [CW-1:0]  rd_full;
    logic           we;
    logic [EW-1:0]  wd;

    // scan
    logic [UW:0]          r_lo;
    logic                 r_found;
    logic signed [GW-1:0] r_best;
    logic [CW-1:0]        r_best_idx;
    logic [UW-1:0]        r_pos;
    logic [NW-1:0]        r_need;
    logic [UW-1:0]        cur_start, cur_len;
    logic [UW:0]          end_sum;
    logic [HW-1:0]        hi;
    logic signed [GW-1:0] gap;
    logic                 fit;
    logic [NW-1:0]        need_w;
    logic                 last;

    // divider
    logic           div_busy;
    logic [DW-1:0]  quot;
    logic [CFW-1:0] rem;

    // result
    wfa_pkg::t_status r_st;
    logic [DW-1:0]    r_res_addr;
    logic [PW-1:0]    prod;
    logic             r_out_valid;
    logic [DW-1:0]    r_o_addr;
    wfa_pkg::t_status r_o_st;

    assign unit = (r_unit_bytes == '0) ? CFW'(1) : r_unit_bytes;

    wfa_div #(.DW(DW), .VW(CFW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.op == wfa_pkg::OP_DIV),
        .i_dividend ((r_req == wfa_pkg::REQ_ALLOC) ? r_size : r_addr),
        .i_divisor  (unit),
        .o_busy     (div_busy),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    assign cur_start = r_rd[EW-1:UW];
    assign cur_len   = r_rd[UW-1:0];
    assign end_sum   = {1'b0, cur_start} + {1'b0, cur_len};
    assign last      = (r_idx == r_count);
    assign hi        = last ? HW'(r_total_units) : HW'(cur_start);
    assign gap       = $signed({2'b00, hi}) - $signed(GW'(r_lo));
    assign fit       = !gap[GW-1] && (CMPW'(gap) >= CMPW'(r_need))
                       && (!r_found || (gap > r_best));
    assign need_w    = {1'b0, quot} + NW'(rem != '0);
    assign prod      = PW'(r_pos) * PW'(unit);

    always_comb begin
        o_sts.req       = r_req;
        o_sts.size_zero = (r_size == '0);
        o_sts.full      = (r_count >= CW'(MAX_BLOCKS));
        o_sts.div_busy  = div_busy;
        o_sts.bad_addr  = (quot >= DW'(r_total_units)) || (rem != '0);
        o_sts.scan_last = last;
        o_sts.found     = r_found || fit;
        o_sts.match     = (DW'(cur_start) == quot);
        o_sts.at_target = (r_idx == r_best_idx);
        o_sts.del_last  = ((r_idx + CW'(1)) == r_count);
        o_sts.out_busy  = r_out_valid && !i_out_ready;
    end

    // Index walk and table writes; the read address follows the next index.
    always_comb begin
        n_idx  = r_idx;
        n_mode = r_mode;
        we     = 1'b0;
        wd     = r_rd;
        unique case (i_cmd.op)
            wfa_pkg::OP_SCAN_INIT: begin
                n_idx  = '0;
                n_mode = wfa_pkg::MODE_SCAN;
            end
            wfa_pkg::OP_SCAN: begin
                if (last) begin
                    n_idx  = r_count;
                    n_mode = wfa_pkg::MODE_INS;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            wfa_pkg::OP_INS: begin
                we = 1'b1;
                if (r_idx == r_best_idx) begin
                    wd = {r_pos, r_need[UW-1:0]};
                end else begin
                    n_idx = r_idx - CW'(1);
                end
            end
            wfa_pkg::OP_FSCAN: begin
                if (!last && (DW'(cur_start) == quot)) begin
                    n_mode = wfa_pkg::MODE_DEL;
                end else begin
                    n_idx = r_idx + CW'(1);
                end
            end
            wfa_pkg::OP_DEL: begin
                if ((r_idx + CW'(1)) != r_count) begin
                    we    = 1'b1;
                    n_idx = r_idx + CW'(1);
                end
            end
            default: begin
            end
        endcase
        unique case (n_mode)
            wfa_pkg::MODE_INS: rd_full = n_idx - CW'(1);
            wfa_pkg::MODE_DEL: rd_full = n_idx + CW'(1);
            default:           rd_full = n_idx;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[r_idx[AW-1:0]] <= wd;
        end
        r_rd <= r_mem[rd_full[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_bytes  <= wfa_pkg::UNIT_BYTES_RST;
            r_total_units <= wfa_pkg::TOTAL_UNITS_RST;
            r_count       <= '0;
            r_idx         <= '0;
            r_mode        <= wfa_pkg::MODE_SCAN;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == wfa_pkg::CFG_UNIT_BYTES) begin
                    r_unit_bytes <= i_cfg_data;
                end else begin
                    r_total_units <= i_cfg_data;
                end
            end
            r_idx  <= n_idx;
            r_mode <= n_mode;
            unique case (i_cmd.op)
                wfa_pkg::OP_CLEAR: r_count <= '0;
                wfa_pkg::OP_SCAN_INIT: r_found <= 1'b0;
                wfa_pkg::OP_SCAN: begin
                    if (fit) begin
                        r_found <= 1'b1;
                    end
                end
                wfa_pkg::OP_INS: begin
                    if (r_idx == r_best_idx) begin
                        r_count <= r_count + CW'(1);
                    end
                end
                wfa_pkg::OP_DEL: begin
                    if ((r_idx + CW'(1)) == r_count) begin
                        r_count <= r_count - CW'(1);
                    end
                end
                default: begin
                end
            endcase
            if (i_cmd.op == wfa_pkg::OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == wfa_pkg::OP_ACCEPT) begin
            r_req      <= wfa_pkg::t_req'(i_in_user);
            r_size     <= i_in_data[DW-1:0];
            r_addr     <= i_in_data[2*DW-1:DW];
            r_res_addr <= '0;
        end
        if (i_cmd.op == wfa_pkg::OP_SCAN_INIT) begin
            r_lo   <= '0;
            r_need <= need_w;
        end
        if (i_cmd.op == wfa_pkg::OP_SCAN) begin
            r_lo <= end_sum;
            if (fit) begin
                r_best     <= gap;
                r_best_idx <= r_idx;
                r_pos      <= r_lo[UW-1:0];
            end
        end
        if ((i_cmd.op == wfa_pkg::OP_INS) && (r_idx == r_best_idx)) begin
            r_res_addr <= DW'(prod);
        end
        if (i_cmd.set_st) begin
            r_st <= i_cmd.st;
        end
        if (i_cmd.op == wfa_pkg::OP_OUT) begin
            r_o_st   <= r_st;
            r_o_addr <= r_res_addr;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_o_addr;
    assign o_out_user  = r_o_st;
endmodule

/* sv/wfa_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine of the allocator.
// Depends on wfa_pkg.
module wfa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  wfa_pkg::t_sts i_sts,
    output wfa_pkg::t_cmd o_cmd,
    output logic          o_in_ready
);
    wfa_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wfa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wfa_pkg::S_IDLE: begin
                if (i_in_valid) n_state = wfa_pkg::S_DECIDE;
            end
            wfa_pkg::S_DECIDE: begin
                priority case (i_sts.req)
                    wfa_pkg::REQ_ALLOC: begin
                        if (i_sts.size_zero || i_sts.full) n_state = wfa_pkg::S_DONE;
                        else n_state = wfa_pkg::S_DIV;
                    end
                    wfa_pkg::REQ_FREE: n_state = wfa_pkg::S_DIV;
                    default:           n_state = wfa_pkg::S_DONE;
                endcase
            end
            wfa_pkg::S_DIV: begin
                if (!i_sts.div_busy) begin
                    if (i_sts.req == wfa_pkg::REQ_ALLOC) n_state = wfa_pkg::S_SCAN;
                    else if (i_sts.bad_addr)             n_state = wfa_pkg::S_DONE;
                    else                                 n_state = wfa_pkg::S_FSCAN;
                end
            end
            wfa_pkg::S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = i_sts.found ? wfa_pkg::S_INS : wfa_pkg::S_DONE;
                end
            end
            wfa_pkg::S_INS: begin
                if (i_sts.at_target) n_state = wfa_pkg::S_DONE;
            end
            wfa_pkg::S_FSCAN: begin
                if (i_sts.scan_last)  n_state = wfa_pkg::S_DONE;
                else if (i_sts.match) n_state = wfa_pkg::S_DEL;
            end
            wfa_pkg::S_DEL: begin
                if (i_sts.del_last) n_state = wfa_pkg::S_DONE;
            end
            wfa_pkg::S_DONE: begin
                if (!i_sts.out_busy) n_state = wfa_pkg::S_IDLE;
            end
            default: n_state = wfa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op     = wfa_pkg::OP_NONE;
        o_cmd.set_st = 1'b0;
        o_cmd.st     = wfa_pkg::ST_OK;
        o_in_ready   = 1'b0;
        unique case (r_state)
            wfa_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = wfa_pkg::OP_ACCEPT;
            end
            wfa_pkg::S_DECIDE: begin
                priority case (i_sts.req)
                    wfa_pkg::REQ_ALLOC: begin
                        o_cmd.set_st = 1'b1;
                        if (i_sts.size_zero) begin
                            o_cmd.st = wfa_pkg::ST_SIZE_ZERO;
                        end else if (i_sts.full) begin
                            o_cmd.st = wfa_pkg::ST_FULL;
                        end else begin
                            o_cmd.set_st = 1'b0;
                            o_cmd.op     = wfa_pkg::OP_DIV;
                        end
                    end
                    wfa_pkg::REQ_FREE: o_cmd.op = wfa_pkg::OP_DIV;
                    wfa_pkg::REQ_CLEAR: begin
                        o_cmd.op     = wfa_pkg::OP_CLEAR;
                        o_cmd.set_st = 1'b1;
                    end
                    default: o_cmd.set_st = 1'b1;
                endcase
            end
            wfa_pkg::S_DIV: begin
                if (!i_sts.div_busy) begin
                    if ((i_sts.req != wfa_pkg::REQ_ALLOC) && i_sts.bad_addr) begin
                        o_cmd.set_st = 1'b1;
                        o_cmd.st     = wfa_pkg::ST_BAD_ADDR;
                    end else begin
                        o_cmd.op = wfa_pkg::OP_SCAN_INIT;
                    end
                end
            end
            wfa_pkg::S_SCAN: begin
                o_cmd.op = wfa_pkg::OP_SCAN;
                if (i_sts.scan_last && !i_sts.found) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = wfa_pkg::ST_NO_FIT;
                end
            end
            wfa_pkg::S_INS: begin
                o_cmd.op     = wfa_pkg::OP_INS;
                o_cmd.set_st = i_sts.at_target;
            end
            wfa_pkg::S_FSCAN: begin
                o_cmd.op = wfa_pkg::OP_FSCAN;
                if (i_sts.scan_last) begin
                    o_cmd.set_st = 1'b1;
                    o_cmd.st     = wfa_pkg::ST_NOT_ALLOC;
                end
            end
            wfa_pkg::S_DEL: begin
                o_cmd.op     = wfa_pkg::OP_DEL;
                o_cmd.set_st = i_sts.del_last;
            end
            wfa_pkg::S_DONE: begin
                if (!i_sts.out_busy) o_cmd.op = wfa_pkg::OP_OUT;
            end
            default: begin
            end
        endcase
    end
endmodule

/* sv/worst_fit_allocator.sv */
`timescale 1ns / 1ps
// Top level of the worst-fit allocator: controller plus datapath.
// Depends on wfa_pkg, wfa_ctrl, wfa_dp (and wfa_div below it).
//
//  channel   direction  handshake              payload
//  s_axis    in         tvalid/tready          tdata {address, size_bytes}, tuser req_type
//  m_axis    out        tvalid/tready          tdata block_address, tuser status
//  cfg       in         i_cfg_we (no wait)     i_cfg_index, i_cfg_data
//
// How long a request keeps the block busy depends on its type and on the n table
// entries: a clear, unknown, zero-size or full-table request skips the divider and
// the table; an allocate divides, scans all n entries, then moves the entries from
// the chosen gap g onward up by one; a free divides, then walks the table to the
// matching entry and moves the later entries down. The table port reads one entry
// per cycle.
// Reset clears the entry count and restores the config; table contents need
// no clearing. The result register holds a finished result while the next
// request is taken; a request waits in its final state only if that register
// is still full.
module worst_fit_allocator #(
    parameter int MAX_BLOCKS = wfa_pkg::DEF_MAX_BLOCKS,
    parameter int UNIT_WIDTH = wfa_pkg::DEF_UNIT_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration writes
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [wfa_pkg::CFG_W-1:0]     i_cfg_data,
    // request channel
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [2*wfa_pkg::DATA_W-1:0]  s_axis_tdata,  // [31:0] size_bytes, [63:32] address
    input  logic [wfa_pkg::REQ_W-1:0]     s_axis_tuser,  // [1:0] req_type
    // result channel
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [wfa_pkg::DATA_W-1:0]    m_axis_tdata,  // [31:0] block_address
    output logic [wfa_pkg::STATUS_W-1:0]  m_axis_tuser   // [2:0] status
);
    wfa_pkg::t_cmd cmd;
    wfa_pkg::t_sts sts;

    // sequence each request through decide and, as it needs, divide, scan and table update
    wfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (s_axis_tready)
    );

    // table, divider, gap search and result register
    wfa_dp #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .UNIT_WIDTH (UNIT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

    // a request keeps the block busy in the cycle after it is taken
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while previous one still in flight");

    // only a successful allocate carries a nonzero address
    a_addr_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != wfa_pkg::ST_OK)) |-> (m_axis_tdata == '0))
        else $error("failed request returned a block address");

    // a result appears only when the controller loads the output register
    a_out_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(cmd.op == wfa_pkg::OP_OUT))
        else $error("result valid without an output load");
endmodule
